// ===== rtl/rgbam_pkg.sv =====
`default_nettype none

package rgbam_pkg;

    // Fixed field widths of the pixel interface.
    localparam int CHAN_W    = 8;
    localparam int MASK_W    = 32;
    localparam int PIX_W     = 32;
    localparam int NUM_CHAN  = 3;
    localparam int SHIFT_W   = 5;
    localparam int WIDTH_W   = 6;
    localparam int LO_W      = 7;
    localparam int CFG_IDX_W = 2;

    // Channel order inside the per-channel arrays.
    localparam int CHAN_RED   = 0;
    localparam int CHAN_GREEN = 1;
    localparam int CHAN_BLUE  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RED_MASK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_MASK  = 2'd2;

    localparam logic [MASK_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [MASK_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [MASK_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;

    // floor(x / 255) is exact as (x * 0x8081) >> 23 for any 16-bit x.
    localparam logic [15:0] DIV255_RECIP = 16'h8081;
    localparam int          DIV255_SHIFT = 23;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb8_t;
    typedef logic [NUM_CHAN-1:0][PIX_W-1:0]  chan_word_t;

    // Placement of one channel: floor(v * (2^w - 1) / 255) is split into
    // v * mult_hi + floor(v * mult_lo / 255), then shifted left by shift.
    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [PIX_W-1:0]   mult_hi;
        logic [LO_W-1:0]    mult_lo;
    } chan_fmt_t;

    typedef chan_fmt_t [NUM_CHAN-1:0] chan_fmt_arr_t;

    function automatic logic [CHAN_W-1:0] div255_16(input logic [15:0] x);
        logic [31:0] prod;
        prod = 32'(x) * 32'(DIV255_RECIP);
        return prod[DIV255_SHIFT +: CHAN_W];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rgbam_blend.sv =====
`default_nettype none

module rgbam_blend
    import rgbam_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire rgb8_t             color,
    input  wire logic [CHAN_W-1:0] alpha,
    output logic                   out_valid,
    output rgb8_t                  blended
);

    logic [NUM_CHAN-1:0][15:0] sum_next;
    logic [NUM_CHAN-1:0][15:0] sum_reg;
    rgb8_t                     blend_next;
    rgb8_t                     blend_reg;
    logic                      sum_valid_reg;
    logic                      blend_valid_reg;
    logic [CHAN_W-1:0]         inv_alpha;

    // c*a + 255*(255-a), with 255*k written as (k << 8) - k.
    always_comb
    begin
        inv_alpha = ~alpha;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            sum_next[c] = 16'(color[c]) * 16'(alpha) + {inv_alpha, 8'h00}
                          - 16'(inv_alpha);
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            blend_next[c] = div255_16(sum_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        blend_reg <= blend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg   <= 1'b0;
            blend_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg   <= in_valid;
            blend_valid_reg <= sum_valid_reg;
        end
    end

    assign out_valid = blend_valid_reg;
    assign blended   = blend_reg;

`ifndef SYNTHESIS
    // Blending over white never darkens a channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (blended[CHAN_RED] >= $past(color[CHAN_RED], 2)) &&
                      (blended[CHAN_GREEN] >= $past(color[CHAN_GREEN], 2)) &&
                      (blended[CHAN_BLUE] >= $past(color[CHAN_BLUE], 2)))
        else $error("blended channel darker than its source");

    // A fully transparent pixel shows pure white.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ($past(alpha, 2) == 8'd0) |-> (blended == {NUM_CHAN{8'hFF}}))
        else $error("transparent pixel did not blend to white");
`endif

endmodule

`default_nettype wire

// ===== rtl/rgbam_fmt.sv =====
`default_nettype none

module rgbam_fmt
    import rgbam_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [MASK_W-1:0] mask,
    output chan_fmt_t              fmt
);

    logic [MASK_W-1:0]  low_bit;
    logic [MASK_W-1:0]  run_bits;
    logic [SHIFT_W-1:0] shift_next;
    logic [WIDTH_W-1:0] width_next;
    logic [SHIFT_W-1:0] shift_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [PIX_W-1:0]   byte_ones;
    logic [2:0]         rem_bits;
    chan_fmt_t          fmt_next;
    chan_fmt_t          fmt_reg;

    // Adding the lowest set bit clears the lowest run of ones; the bits that
    // changed and were set in the mask are that run.
    always_comb
    begin
        low_bit    = mask & (~mask + 32'd1);
        run_bits   = mask & ~(mask + low_bit);
        shift_next = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (low_bit[i])
            begin
                shift_next = shift_next | SHIFT_W'(i);
            end
        end
        width_next = WIDTH_W'($countones(run_bits));
    end

    // Since 256 = 1 mod 255: (2^w - 1) = 255 * (2^r * 0x0101..) + (2^r - 1),
    // with w = 8k + r and k bytes of 0x01.
    always_comb
    begin
        rem_bits  = width_reg[2:0];
        byte_ones = '0;
        for (int i = 0; i < PIX_W / 8; i++)
        begin
            byte_ones[8*i] = (width_reg[WIDTH_W-1:3] > 3'(i));
        end
        fmt_next.shift   = shift_reg;
        fmt_next.mult_hi = byte_ones << rem_bits;
        fmt_next.mult_lo = LO_W'((8'd1 << rem_bits) - 8'd1);
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        width_reg <= width_next;
        fmt_reg   <= fmt_next;
    end

    assign fmt = fmt_reg;

endmodule

`default_nettype wire

// ===== rtl/rgbam_scale.sv =====
`default_nettype none

module rgbam_scale
    import rgbam_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire rgb8_t         value,
    input  wire chan_fmt_arr_t fmt,
    output logic               out_valid,
    output chan_word_t         scaled
);

    chan_word_t                hi_reg;
    chan_word_t                hi_d_reg;
    logic [NUM_CHAN-1:0][15:0] lo_reg;
    rgb8_t                     quot_reg;
    chan_word_t                sum_reg;
    logic [2:0]                valid_reg;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            // The whole product stays below 2^32 because it never exceeds
            // the channel's full-scale value.
            hi_reg[c]   <= PIX_W'(value[c]) * fmt[c].mult_hi;
            lo_reg[c]   <= 16'(value[c]) * 16'(fmt[c].mult_lo);
            quot_reg[c] <= div255_16(lo_reg[c]);
            hi_d_reg[c] <= hi_reg[c];
            sum_reg[c]  <= hi_d_reg[c] + PIX_W'(quot_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    assign out_valid = valid_reg[2];
    assign scaled    = sum_reg;

endmodule

`default_nettype wire

// ===== rtl/rgba_blend_to_masked_pixel_unit.sv =====
`default_nettype none

// Channel    Direction  Signals                                  Beat taken when
// ---------  ---------  ---------------------------------------  ---------------------
// pixel in   input      start, busy, red_in, green_in,           start high, busy low
//                       blue_in, alpha_in
// result     output     done, packed_pixel                       every cycle done is high
// config     input      cfg_write, cfg_index, cfg_wdata          every cycle cfg_write high
//
// One pixel beat may enter on every clock; busy is held low. Each beat passes
// through six register stages: blend sum, divide by 255, scale products,
// divide by 255 again, scale sum, and the packing register. Reset clears
// the valid bits and restores the default 8:8:8 masks; the mask decoders
// settle through their decoder registers after reset or a write.
// The receiver cannot stall, so results are shown for one cycle only.
module rgba_blend_to_masked_pixel_unit
    import rgbam_pkg::*;
#(
    parameter int PIXEL_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [CHAN_W-1:0]    red_in,
    input  wire logic [CHAN_W-1:0]    green_in,
    input  wire logic [CHAN_W-1:0]    blue_in,
    input  wire logic [CHAN_W-1:0]    alpha_in,
    output logic                      done,
    output logic [PIX_W-1:0]          packed_pixel,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MASK_W-1:0]    cfg_wdata
);

    // Mask bits at or above the pixel word width are ignored.
    localparam int unsigned      MASK_BITS = (PIXEL_BITS < MASK_W) ? PIXEL_BITS : MASK_W;
    localparam logic [MASK_W-1:0] WORD_MASK = 32'hFFFF_FFFF >> (MASK_W - MASK_BITS);
    localparam int                LATENCY   = 6;

    logic [NUM_CHAN-1:0][MASK_W-1:0] mask_reg;
    logic [NUM_CHAN-1:0][MASK_W-1:0] mask_eff;
    chan_fmt_arr_t                   fmt;
    rgb8_t                           color_in;
    rgb8_t                           blended;
    logic                            blend_valid;
    chan_word_t                      scaled;
    logic                            scale_valid;
    logic                            accept;
    logic [PIX_W-1:0]                pixel_next;
    logic [PIX_W-1:0]                pixel_reg;
    logic                            done_reg;

    // The pipeline takes a new pixel every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration registers. Writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg[CHAN_RED]   <= RED_MASK_RST;
            mask_reg[CHAN_GREEN] <= GREEN_MASK_RST;
            mask_reg[CHAN_BLUE]  <= BLUE_MASK_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RED_MASK:   mask_reg[CHAN_RED]   <= cfg_wdata;
                REG_GREEN_MASK: mask_reg[CHAN_GREEN] <= cfg_wdata;
                REG_BLUE_MASK:  mask_reg[CHAN_BLUE]  <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Each mask is decoded continuously into a shift and a pair of scale factors.
    // The user must change masks only while no pixel is in flight; the block does not enforce this,
    // and the decoded values are ready before the first pixel reaches the scaler.
    for (genvar c = 0; c < NUM_CHAN; c++)
    begin : g_fmt
        assign mask_eff[c] = mask_reg[c] & WORD_MASK;

        rgbam_fmt u_fmt (
            .clk  (clk),
            .mask (mask_eff[c]),
            .fmt  (fmt[c])
        );
    end

    assign color_in[CHAN_RED]   = red_in;
    assign color_in[CHAN_GREEN] = green_in;
    assign color_in[CHAN_BLUE]  = blue_in;

    // Two stages: blend over white, then the exact divide by 255.
    rgbam_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .color     (color_in),
        .alpha     (alpha_in),
        .out_valid (blend_valid),
        .blended   (blended)
    );

    // Three stages: rescale each 8-bit value to its field's full scale.
    rgbam_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (blend_valid),
        .value     (blended),
        .fmt       (fmt),
        .out_valid (scale_valid),
        .scaled    (scaled)
    );

    // Final stage: shift each channel into place and merge. The scaled value
    // fits inside its mask run, so nothing spills past the word.
    always_comb
    begin
        pixel_next = '0;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            pixel_next = pixel_next | (scaled[c] << fmt[c].shift);
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= scale_valid;
        end
    end

    assign done         = done_reg;
    assign packed_pixel = pixel_reg;

`ifndef SYNTHESIS
    // Every accepted pixel produces a result on done.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted pixel produced no result");

    // No result appears without a pixel accepted at the matching time.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching input pixel");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none

// Testbench for the RGBA blend and mask pack unit.
//
// A stimulus process drives pixel beats and mask writes on the falling edge.
// A monitor samples everything on the rising edge. For every accepted pixel
// beat it pushes one expected packed word, the row's typed answer or else the
// word from a local blend and pack model using its own copy of the three mask
// registers. Every done beat is compared against the oldest one in that queue.
module tb
    import rgbam_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIXEL_BITS     = 32;
    localparam int RESET_CYCLES   = 7;
    localparam int PIPE_LATENCY   = 6;
    // Wait for the mask decoders to settle after a write, with margin added.
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SEGMENT_BEATS  = 154;
    localparam int SEGMENTS       = 4;

    // Index 3 is not a register. A write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    // Mask sets used by the directed table.
    localparam logic [1:0] SET_RESET   = 2'd0;
    localparam logic [1:0] SET_WIDE    = 2'd1;
    localparam logic [1:0] SET_BROKEN  = 2'd2;
    localparam logic [1:0] SET_OVERLAP = 2'd3;

    typedef logic [0:NUM_CHAN-1][MASK_W-1:0] mask_triple_t;

    localparam mask_triple_t MASK_SETS [4] = '{
        '{RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST},
        // Zero masks on red and blue, and a green field that fills the word.
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000},
        // Broken masks: only the lowest run of each one may count.
        '{32'h0F0F_0000, 32'h8000_0001, 32'h8000_0000},
        // Overlapping masks that get ORed together.
        '{32'h0000_FFFF, 32'h00FF_FF00, 32'hFFFF_0000}
    };

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [1:0]        mask_set;
        logic              has_answer;
        logic [PIX_W-1:0]  answer;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 19;

    // A typed answer is only given where it is plain to see. Opaque pixels pass
    // through unchanged, and transparent ones turn white. The remaining rows
    // are checked against the model.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00, 8'h00, 8'h00, 8'hFF, SET_RESET,   1'b1, 32'h0000_0000},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, SET_RESET,   1'b1, 32'h00FF_FFFF},
        '{8'h12, 8'h34, 8'h56, 8'h00, SET_RESET,   1'b1, 32'h00FF_FFFF},
        '{8'hFF, 8'h00, 8'h00, 8'hFF, SET_RESET,   1'b1, 32'h00FF_0000},
        '{8'h00, 8'hFF, 8'h00, 8'hFF, SET_RESET,   1'b1, 32'h0000_FF00},
        '{8'h00, 8'h00, 8'hFF, 8'hFF, SET_RESET,   1'b1, 32'h0000_00FF},
        '{8'h12, 8'h34, 8'h56, 8'hFF, SET_RESET,   1'b1, 32'h0012_3456},
        '{8'h80, 8'h40, 8'hC0, 8'h80, SET_RESET,   1'b0, 32'h0},
        '{8'h00, 8'h00, 8'h00, 8'h01, SET_RESET,   1'b0, 32'h0},
        '{8'hFF, 8'h00, 8'h7F, 8'hFE, SET_RESET,   1'b0, 32'h0},
        '{8'hFF, 8'h00, 8'hFF, 8'h00, SET_WIDE,    1'b1, 32'hFFFF_FFFF},
        '{8'hFF, 8'h00, 8'hFF, 8'hFF, SET_WIDE,    1'b1, 32'h0000_0000},
        '{8'hAA, 8'h55, 8'hAA, 8'h7F, SET_WIDE,    1'b0, 32'h0},
        '{8'h00, 8'h00, 8'h00, 8'h00, SET_BROKEN,  1'b1, 32'h800F_0001},
        '{8'h00, 8'h00, 8'h00, 8'hFF, SET_BROKEN,  1'b1, 32'h0000_0000},
        '{8'hFF, 8'h80, 8'h7F, 8'hFF, SET_BROKEN,  1'b0, 32'h0},
        '{8'h00, 8'h00, 8'h00, 8'h00, SET_OVERLAP, 1'b1, 32'hFFFF_FFFF},
        '{8'hC3, 8'h3C, 8'h5A, 8'h90, SET_OVERLAP, 1'b0, 32'h0},
        '{8'h01, 8'hFE, 8'h80, 8'hFF, SET_OVERLAP, 1'b0, 32'h0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [CHAN_W-1:0]    red_in;
    logic [CHAN_W-1:0]    green_in;
    logic [CHAN_W-1:0]    blue_in;
    logic [CHAN_W-1:0]    alpha_in;
    logic                 done;
    logic [PIX_W-1:0]     packed_pixel;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MASK_W-1:0]    cfg_wdata;

    // These signals travel with each pixel beat. When row_has_answer is high,
    // the monitor queues row_answer in place of the model's value.
    logic             row_has_answer;
    logic [PIX_W-1:0] row_answer;

    logic [PIX_W-1:0] expected_pixels [$];
    logic [MASK_W-1:0] mask_copy [NUM_CHAN];
    int error_count;
    int quiet_cycles;

    rgba_blend_to_masked_pixel_unit #(
        .PIXEL_BITS(PIXEL_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .alpha_in    (alpha_in),
        .done        (done),
        .packed_pixel(packed_pixel),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Blend and pack model
    // ------------------------------------------------------------------

    // A color channel blended over white, truncated.
    function automatic logic [CHAN_W-1:0] blend_over_white(input logic [CHAN_W-1:0] c,
                                                           input logic [CHAN_W-1:0] a);
        int unsigned sum;
        sum = c * a + 255 * (255 - a);
        return CHAN_W'(sum / 255);
    endfunction

    // This function scales an 8-bit value to the width of the lowest run of
    // ones in the mask. It then shifts the result to the start of that run.
    function automatic logic [63:0] place_in_mask(input logic [CHAN_W-1:0] v,
                                                  input logic [MASK_W-1:0] mask);
        logic [63:0] m;
        logic [63:0] top;
        logic [63:0] scaled;
        int shift;
        int width;
        if (PIXEL_BITS >= 64)
            m = 64'(mask);
        else
            m = 64'(mask) & ((64'd1 << PIXEL_BITS) - 64'd1);
        if (m == 64'd0)
            return 64'd0;
        shift = 0;
        width = 0;
        while (m[0] == 1'b0)
        begin
            m = m >> 1;
            shift++;
        end
        while (m[0] == 1'b1 && width < 32)
        begin
            m = m >> 1;
            width++;
        end
        top = (64'd1 << width) - 64'd1;
        scaled = (64'(v) * top) / 64'd255;
        return scaled << shift;
    endfunction

    function automatic logic [PIX_W-1:0] blend_and_pack(input logic [CHAN_W-1:0] r,
                                                        input logic [CHAN_W-1:0] g,
                                                        input logic [CHAN_W-1:0] b,
                                                        input logic [CHAN_W-1:0] a);
        logic [63:0] word;
        word = place_in_mask(blend_over_white(r, a), mask_copy[CHAN_RED])
             | place_in_mask(blend_over_white(g, a), mask_copy[CHAN_GREEN])
             | place_in_mask(blend_over_white(b, a), mask_copy[CHAN_BLUE]);
        if (PIXEL_BITS < 64)
            word = word & ((64'd1 << PIXEL_BITS) - 64'd1);
        return PIX_W'(word);
    endfunction

    task automatic flag_mismatch(input string what, input logic [PIX_W-1:0] want,
                                 input logic [PIX_W-1:0] got);
        $display("%0t ns: MISMATCH %s: expected %08h, got %08h", $time, what, want, got);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------

    // The monitor samples on the rising edge. Inputs change only on the
    // falling edge, so each sample is stable. The DUT's outputs still hold
    // their values from before the edge. A mask write and a pixel beat never
    // occur in the same cycle, so the mask copy can be updated in place.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mask_copy[CHAN_RED]   = RED_MASK_RST;
            mask_copy[CHAN_GREEN] = GREEN_MASK_RST;
            mask_copy[CHAN_BLUE]  = BLUE_MASK_RST;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_RED_MASK:   mask_copy[CHAN_RED]   = cfg_wdata;
                    REG_GREEN_MASK: mask_copy[CHAN_GREEN] = cfg_wdata;
                    REG_BLUE_MASK:  mask_copy[CHAN_BLUE]  = cfg_wdata;
                    default:        ;
                endcase
            end
            if (start && !busy)
            begin
                if (row_has_answer)
                    expected_pixels.push_back(row_answer);
                else
                    expected_pixels.push_back(blend_and_pack(red_in, green_in,
                                                             blue_in, alpha_in));
            end
            if (done)
            begin
                if (expected_pixels.size() == 0)
                    flag_mismatch("result beat with nothing expected", '0, packed_pixel);
                else if (packed_pixel !== expected_pixels[0])
                    flag_mismatch("packed_pixel", expected_pixels[0], packed_pixel);
                if (expected_pixels.size() != 0)
                    void'(expected_pixels.pop_front());
            end
        end
    end

    // The watchdog ends the run after too many cycles in which no beat of any
    // kind was accepted. A healthy run never has a quiet stretch anywhere
    // near this length.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_write)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // This task is called at a falling edge and returns at a falling edge.
    // Start is lowered only when the beat is preceded by a gap. A beat that
    // follows back to back keeps start high without a glitch.
    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] a,
                              input logic has_answer, input logic [PIX_W-1:0] answer,
                              input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start          <= 1'b1;
        red_in         <= r;
        green_in       <= g;
        blue_in        <= b;
        alpha_in       <= a;
        row_has_answer <= has_answer;
        row_answer     <= answer;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // This task stops sending and waits until every queued pixel has come
    // back. With one result per beat, an empty queue means the pipeline is
    // empty as well.
    task automatic drain_pipeline();
        start <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
    endtask

    // The block must be idle before the masks are written. After the three
    // registers, the unmapped index also gets a random write, which the block
    // must ignore. The decoders then get time to settle.
    task automatic load_masks(input mask_triple_t masks);
        drain_pipeline();
        cfg_write <= 1'b1;
        cfg_index <= REG_RED_MASK;
        cfg_wdata <= masks[CHAN_RED];
        @(negedge clk);
        cfg_index <= REG_GREEN_MASK;
        cfg_wdata <= masks[CHAN_GREEN];
        @(negedge clk);
        cfg_index <= REG_BLUE_MASK;
        cfg_wdata <= masks[CHAN_BLUE];
        @(negedge clk);
        cfg_index <= REG_UNMAPPED;
        cfg_wdata <= $urandom();
        @(negedge clk);
        cfg_write <= 1'b0;
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // The random masks are most often clean runs. The rest are zero, full, byte
    // lanes, runs with loose bits above them, and plain noise.
    function automatic logic [MASK_W-1:0] random_mask();
        int unsigned pick;
        int unsigned lo;
        int unsigned len;
        logic [63:0] run;
        logic [63:0] keep_low;
        pick = $urandom_range(0, 99);
        lo   = $urandom_range(0, 31);
        len  = $urandom_range(1, 32 - lo);
        run  = ((64'd1 << len) - 64'd1) << lo;
        keep_low = (64'd1 << (lo + len + 1)) - 64'd1;
        if (pick < 8)
            return '0;
        else if (pick < 16)
            return '1;
        else if (pick < 30)
            return MASK_W'(32'h0000_00FF << (8 * $urandom_range(0, 3)));
        else if (pick < 42)
            return $urandom();
        else if (pick < 60)
            return run[MASK_W-1:0] | (MASK_W'($urandom()) & ~keep_low[MASK_W-1:0]);
        else
            return run[MASK_W-1:0];
    endfunction

    // The extreme values get extra weight on every channel.
    function automatic logic [CHAN_W-1:0] random_channel();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        else
            return CHAN_W'($urandom());
    endfunction

    // This function counts idle cycles before a beat. Each cycle idles with
    // the given percentage.
    function automatic int idle_gap(input int unsigned percent);
        int n;
        n = 0;
        while ($urandom_range(0, 99) < percent)
            n++;
        return n;
    endfunction

    initial
    begin : stimulus
        int unsigned idle_percent [3];
        int calm_left;
        int gap;
        logic [1:0] active_set;
        mask_triple_t masks;

        idle_percent = '{6, 53, 0};
        calm_left  = 0;
        active_set = SET_RESET;

        error_count    = 0;
        quiet_cycles   = 0;
        rst_n          = 1'b0;
        start          = 1'b0;
        red_in         = '0;
        green_in       = '0;
        blue_in        = '0;
        alpha_in       = '0;
        cfg_write      = 1'b0;
        cfg_index      = REG_RED_MASK;
        cfg_wdata      = '0;
        row_has_answer = 1'b0;
        row_answer     = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(negedge clk);

        // The directed table starts with the reset masks. A new mask set is
        // loaded wherever the table's set column changes.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].mask_set != active_set)
            begin
                active_set = DIRECTED[i].mask_set;
                load_masks(MASK_SETS[active_set]);
            end
            send_pixel(DIRECTED[i].red, DIRECTED[i].green, DIRECTED[i].blue,
                       DIRECTED[i].alpha, DIRECTED[i].has_answer, DIRECTED[i].answer,
                       $urandom_range(0, 1));
        end

        // The random part has three idling phases: light gaps, heavy gaps, and
        // none. Each phase is split into segments, and each segment uses a
        // fresh set of masks. Calm runs without gaps are mixed into the gappy
        // phases.
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                masks[CHAN_RED]   = random_mask();
                masks[CHAN_GREEN] = random_mask();
                masks[CHAN_BLUE]  = random_mask();
                load_masks(masks);
                for (int n = 0; n < SEGMENT_BEATS; n++)
                begin
                    if (calm_left > 0)
                    begin
                        calm_left--;
                        gap = 0;
                    end
                    else
                    begin
                        if ($urandom_range(0, 49) == 0)
                            calm_left = $urandom_range(20, 60);
                        gap = idle_gap(idle_percent[phase]);
                    end
                    send_pixel(random_channel(), random_channel(), random_channel(),
                               random_channel(), 1'b0, '0, gap);
                end
            end
        end

        // Wait for the last results, then keep watching to catch any stray beat
        // that arrives after them.
        drain_pipeline();
        repeat (PIPE_LATENCY + 4) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ===== rgba_blend_to_masked_pixel_unit.f =====
rtl/rgbam_pkg.sv
rtl/rgbam_blend.sv
rtl/rgbam_fmt.sv
rtl/rgbam_scale.sv
rtl/rgba_blend_to_masked_pixel_unit.sv
verif/tb.sv
